FILE: sv/tcw_pkg.sv
// Shared constants and types for the text console character writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // One screen cell: character in the low byte, attribute in the high byte.
    localparam int CELL_W = 16;

    // Request commands.
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Character and attribute codes.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_E         = 8'h45;
    localparam logic [7:0] DEFAULT_ATTR = 8'h0F;
    localparam logic [7:0] ERROR_ATTR   = 8'h04;
    localparam logic [7:0] BLANK_ATTR   = 8'h0F;

    localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, CH_SPACE};
    localparam logic [CELL_W-1:0] ERROR_CELL = {ERROR_ATTR, CH_E};

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_EXEC   = 7'b0000100,
        ST_RDWAIT = 7'b0001000,
        ST_SCROLL = 7'b0010000,
        ST_FILL   = 7'b0100000,
        ST_RESP   = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

FILE: sv/tcw_cell_mem.sv
// Screen cell memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_mem
    import tcw_pkg::*;
#(
    parameter int DEPTH  = COLUMNS_DEF * ROWS_DEF,
    parameter int ADDR_W = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [CELL_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // A read and a write of the same cell in one cycle return the old value.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/text_console_char_writer.sv
// Top level of the text console character writer: controller, cursor and result register.
// A put, a newline, a backspace, an off-screen request or an unused command ends in the
// execute state, a read in the read-wait state; new requests are taken only in idle.
// A scroll then copies each row below the first one row up and zeroes the last row,
// and a clear sweeps all ROWS*COLUMNS cells, one write a cycle on the memory write port.
// Reset is synchronous and active low; a pass over all ROWS*COLUMNS cells then zeroes
// the cell memory while o_s_tready stays low.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // i_s_tdata, from bit 0 up: cmd[1:0], char_code[9:2], attr[17:10],
    // use_cursor[18], col[26:19], row[34:27], zero fill[39:35].
    input  wire logic [39:0] i_s_tdata,
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // o_m_tdata, from bit 0 up: cursor_col[6:0], cursor_row[11:7],
    // cell_char[19:12], cell_attr[27:20], error[28], zero fill[31:29].
    output logic      [31:0] o_m_tdata
);

    // Geometry derived from the parameters.
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_BASE  = ADDR_W'(CELLS - COLUMNS);

    // Controller and cursor.
    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_cur_col, n_cur_col;
    logic [ROW_W-1:0]   r_cur_row, n_cur_row;

    // The request being worked on. The column and row are checked against the
    // screen as the request is taken, so later stages only see a flag.
    logic [1:0]         r_cmd;
    logic [7:0]         r_char;
    logic [7:0]         r_attr;
    logic               r_use_cur;
    logic [7:0]         r_col;
    logic [7:0]         r_row;
    logic               r_outside;

    // Result fields that are not the cursor.
    logic [7:0]         r_res_char, n_res_char;
    logic [7:0]         r_res_attr, n_res_attr;
    logic               r_res_err, n_res_err;

    // Sweep counter shared by the reset pass, the clear, the scroll copy and
    // the zeroing of the last row.
    logic [ADDR_W-1:0]  r_sweep, n_sweep;
    logic               r_fill_zero, n_fill_zero;

    // The scroll copy reads a cell one row down and writes it in the next cycle,
    // once the read data is back.
    logic               r_cp_valid;
    logic [ADDR_W-1:0]  r_cp_dst;

    // Output register.
    logic               r_out_valid;
    logic [31:0]        r_out_data;

    // Memory ports.
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [CELL_W-1:0]  w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [CELL_W-1:0]  w_rdata;

    // Position the request acts on and its linear cell address.
    logic [COL_W-1:0]   w_pc;
    logic [ROW_W-1:0]   w_pr;
    logic [ADDR_W-1:0]  w_pos_addr;
    logic [7:0]         w_attr;
    logic               w_fin;
    logic               w_slot;
    logic               w_in_acc;
    logic               w_out_load;

    logic [6+COL_W:0]   w_col_ext;
    logic [4+ROW_W:0]   w_row_ext;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_slot     = !r_out_valid || i_m_tready;

    // Only a put may use the cursor; a read always takes the explicit column
    // and row. Explicit values always reach the address, cut to the field widths.
    assign w_pc = (r_cmd == CMD_PUT && r_use_cur) ? r_cur_col : r_col[COL_W-1:0];
    assign w_pr = (r_cmd == CMD_PUT && r_use_cur) ? r_cur_row : r_row[ROW_W-1:0];
    assign w_pos_addr = ADDR_W'(w_pr) * COLS_A + ADDR_W'(w_pc);

    // A zero attribute stands for white on black.
    assign w_attr = (r_attr == 8'h00) ? DEFAULT_ATTR : r_attr;

    always_comb begin
        n_state     = r_state;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_res_char  = r_res_char;
        n_res_attr  = r_res_attr;
        n_res_err   = r_res_err;
        n_sweep     = r_sweep;
        n_fill_zero = r_fill_zero;
        w_fin       = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_sweep;
        w_wdata     = '0;
        w_raddr     = r_sweep;

        // A pending scroll copy owns the write port.
        if (r_cp_valid) begin
            w_we    = 1'b1;
            w_waddr = r_cp_dst;
            w_wdata = w_rdata;
        end

        case (r_state)
            ST_INIT: begin
                // Zero every cell once after reset.
                w_we    = 1'b1;
                w_waddr = r_sweep;
                w_wdata = '0;
                if (r_sweep == CELL_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            ST_IDLE: begin
                n_state = w_in_acc ? ST_EXEC : ST_IDLE;
            end
            ST_EXEC: begin
                n_res_char = 8'h00;
                n_res_attr = 8'h00;
                n_res_err  = 1'b0;
                w_raddr    = w_pos_addr;
                case (r_cmd)
                    CMD_PUT: begin
                        if (!r_use_cur && r_outside) begin
                            // Off screen: mark the last cell, cursor stays.
                            w_we      = 1'b1;
                            w_waddr   = CELL_LAST;
                            w_wdata   = ERROR_CELL;
                            n_res_err = 1'b1;
                            w_fin     = 1'b1;
                        end else if (r_char == CH_BACKSPACE) begin
                            // Backspace at the top left corner writes nothing and leaves the cursor there.
                            if (w_pc != '0 || w_pr != '0) begin
                                w_we    = 1'b1;
                                w_waddr = w_pos_addr - 1'b1;
                                w_wdata = BLANK_CELL;
                                if (w_pc == '0) begin
                                    n_cur_col = COL_LAST;
                                    n_cur_row = w_pr - 1'b1;
                                end else begin
                                    n_cur_col = w_pc - 1'b1;
                                    n_cur_row = w_pr;
                                end
                            end else begin
                                n_cur_col = '0;
                                n_cur_row = '0;
                            end
                            w_fin = 1'b1;
                        end else begin
                            // A printed character or a newline; both may run
                            // off the bottom, which scrolls by one row.
                            if (r_char != CH_NEWLINE) begin
                                w_we    = 1'b1;
                                w_waddr = w_pos_addr;
                                w_wdata = {w_attr, r_char};
                            end
                            if (r_char != CH_NEWLINE && w_pc != COL_LAST) begin
                                n_cur_col = w_pc + 1'b1;
                                n_cur_row = w_pr;
                                w_fin     = 1'b1;
                            end else if (w_pr != ROW_LAST) begin
                                n_cur_col = '0;
                                n_cur_row = w_pr + 1'b1;
                                w_fin     = 1'b1;
                            end else begin
                                n_cur_col = '0;
                                n_cur_row = ROW_LAST;
                                n_sweep   = COLS_A;
                                n_state   = ST_SCROLL;
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        n_cur_col   = '0;
                        n_cur_row   = '0;
                        n_sweep     = '0;
                        n_fill_zero = 1'b0;
                        n_state     = ST_FILL;
                    end
                    CMD_READ: begin
                        if (r_outside) begin
                            n_res_err = 1'b1;
                            w_fin     = 1'b1;
                        end else begin
                            n_state = ST_RDWAIT;
                        end
                    end
                    default: begin
                        w_fin = 1'b1;
                    end
                endcase
            end
            ST_RDWAIT: begin
                n_res_char = w_rdata[7:0];
                n_res_attr = w_rdata[15:8];
                w_fin      = 1'b1;
            end
            ST_SCROLL: begin
                // Read each cell from row 1 on; its copy lands one row up.
                w_raddr = r_sweep;
                if (r_sweep == CELL_LAST) begin
                    n_sweep     = ROW_BASE;
                    n_fill_zero = 1'b1;
                    n_state     = ST_FILL;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            ST_FILL: begin
                // Holds off its first write while the last scroll copy is still pending.
                if (!r_cp_valid) begin
                    w_we    = 1'b1;
                    w_waddr = r_sweep;
                    w_wdata = r_fill_zero ? '0 : BLANK_CELL;
                    if (r_sweep == CELL_LAST) begin
                        w_fin = 1'b1;
                    end else begin
                        n_sweep = r_sweep + 1'b1;
                    end
                end
            end
            ST_RESP: begin
                if (w_slot) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A finished request leaves its result at once when the output
        // register is free, otherwise it waits in the response state.
        if (w_fin) begin
            n_state = w_slot ? ST_IDLE : ST_RESP;
        end
    end

    assign w_out_load = (w_fin || r_state == ST_RESP) && w_slot;

    // Cursor fields are masked or zero-extended to the result widths.
    assign w_col_ext = {7'd0, n_cur_col};
    assign w_row_ext = {5'd0, n_cur_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_sweep     <= '0;
            r_fill_zero <= 1'b1;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_sweep     <= n_sweep;
            r_fill_zero <= n_fill_zero;
            r_cp_valid  <= (r_state == ST_SCROLL);
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_res_char <= n_res_char;
        r_res_attr <= n_res_attr;
        r_res_err  <= n_res_err;
        r_cp_dst   <= r_sweep - COLS_A;
        if (w_in_acc) begin
            r_cmd     <= i_s_tdata[1:0];
            r_char    <= i_s_tdata[9:2];
            r_attr    <= i_s_tdata[17:10];
            r_use_cur <= i_s_tdata[18];
            r_col     <= i_s_tdata[26:19];
            r_row     <= i_s_tdata[34:27];
            r_outside <= (i_s_tdata[26:19] >= 8'(COLUMNS))
                      || (i_s_tdata[34:27] >= 8'(ROWS));
        end
        if (w_out_load) begin
            r_out_data <= {3'd0, n_res_err, n_res_attr, n_res_char,
                           w_row_ext[4:0], w_col_ext[6:0]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    tcw_cell_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The cursor never leaves the screen.
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_col) < COLUMNS) && (32'(r_cur_row) < ROWS))
        else $error("cursor outside the screen");

    // The request side is not ready just after reset is released, as the zeroing starts.
    a_init_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_s_tready)
        else $error("request taken during the reset pass");

    // A copy write only follows a scroll read.
    a_copy_after_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> $past(r_state == ST_SCROLL))
        else $error("copy write without a scroll read");

    // A read result comes straight from the request that issued it.
    a_rdwait_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDWAIT) |-> $past(r_state == ST_EXEC))
        else $error("read wait entered out of order");

endmodule

`default_nettype wire

FILE: sim/console_result_checker.sv
`timescale 1ns / 1ps
// Shadow screen model and scoreboard for the text console request and result streams.
module console_result_checker
    import tcw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [39:0] i_req_data,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [31:0] i_res_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_scroll_count
);

    localparam int COLS         = COLUMNS_DEF;
    localparam int LINES        = ROWS_DEF;
    localparam int SCREEN_CELLS = COLS * LINES;

    typedef struct packed {
        logic [4:0] fill;
        logic [7:0] row;
        logic [7:0] col;
        logic       use_cursor;
        logic [7:0] attr;
        logic [7:0] char_code;
        logic [1:0] cmd;
    } t_console_req;

    typedef struct packed {
        logic [2:0] fill;
        logic       error;
        logic [7:0] cell_attr;
        logic [7:0] cell_char;
        logic [4:0] cur_row;
        logic [6:0] cur_col;
    } t_console_res;

    logic [CELL_W-1:0] shadow_screen [SCREEN_CELLS];
    int                shadow_cursor;
    t_console_res      expected_results [$];

    // Applies one request to the shadow screen and returns the result it should give.
    function automatic t_console_res predict_console_request(input t_console_req req);
        t_console_res res;
        logic [7:0]   attr;
        logic         off_screen;
        int           pos;
        res        = '0;
        attr       = (req.attr == 8'h00) ? DEFAULT_ATTR : req.attr;
        off_screen = (int'(req.col) >= COLS) || (int'(req.row) >= LINES);
        case (req.cmd)
            CMD_PUT: begin
                if (!req.use_cursor && off_screen) begin
                    shadow_screen[SCREEN_CELLS-1] = ERROR_CELL;
                    res.error = 1'b1;
                end else begin
                    pos = req.use_cursor ? shadow_cursor : int'(req.row) * COLS + int'(req.col);
                    if (pos >= SCREEN_CELLS) pos = 0;
                    if (req.char_code == CH_NEWLINE) begin
                        pos = (pos / COLS + 1) * COLS;
                    end else if (req.char_code == CH_BACKSPACE) begin
                        // Backspace at home writes nothing and leaves the cursor at home.
                        if (pos > 0) begin
                            pos--;
                            shadow_screen[pos] = BLANK_CELL;
                        end
                    end else begin
                        shadow_screen[pos] = {attr, req.char_code};
                        pos++;
                    end
                    // Off the end: every row moves up one and the last row is zeroed.
                    if (pos >= SCREEN_CELLS) begin
                        for (int i = 0; i < SCREEN_CELLS - COLS; i++)
                            shadow_screen[i] = shadow_screen[i + COLS];
                        for (int i = SCREEN_CELLS - COLS; i < SCREEN_CELLS; i++)
                            shadow_screen[i] = '0;
                        pos -= COLS;
                        o_scroll_count++;
                    end
                    shadow_cursor = pos;
                end
            end
            CMD_CLEAR: begin
                foreach (shadow_screen[i]) shadow_screen[i] = {DEFAULT_ATTR, CH_SPACE};
                shadow_cursor = 0;
            end
            CMD_READ: begin
                if (off_screen) begin
                    res.error = 1'b1;
                end else begin
                    {res.cell_attr, res.cell_char} =
                        shadow_screen[int'(req.row) * COLS + int'(req.col)];
                end
            end
            default: ;
        endcase
        res.cur_col = 7'(shadow_cursor % COLS);
        res.cur_row = 5'(shadow_cursor / COLS);
        return res;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_console_res got;
        t_console_res want;
        if (!i_rst_n) begin
            foreach (shadow_screen[i]) shadow_screen[i] = '0;
            shadow_cursor = 0;
            o_fail_count   = 0;
            o_scroll_count = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result 0x%h with no request outstanding",
                             $time, i_res_data);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.cur_col !== want.cur_col)
                        report_field("cursor_col", 32'(want.cur_col), 32'(got.cur_col));
                    if (got.cur_row !== want.cur_row)
                        report_field("cursor_row", 32'(want.cur_row), 32'(got.cur_row));
                    if (got.cell_char !== want.cell_char)
                        report_field("cell_char", 32'(want.cell_char), 32'(got.cell_char));
                    if (got.cell_attr !== want.cell_attr)
                        report_field("cell_attr", 32'(want.cell_attr), 32'(got.cell_attr));
                    if (got.error !== want.error)
                        report_field("error", 32'(want.error), 32'(got.error));
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(predict_console_request(i_req_data));
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Stimulus, handshake pacing and verdict for the text console character writer.
module tb_top;
    import tcw_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT  = 10000;
    localparam int         LONG_HOLD       = 64;
    localparam int         RANDOM_CHUNKS   = 7;
    localparam int         CHUNK_ITEMS     = 150;

    typedef struct packed {
        logic [4:0] fill;
        logic [7:0] row;
        logic [7:0] col;
        logic       use_cursor;
        logic [7:0] attr;
        logic [7:0] char_code;
        logic [1:0] cmd;
    } t_console_req;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [39:0] req_data  = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [31:0] res_data;

    int fail_count;
    int pending;
    int scroll_count;

    // Pacing controls shared by the sender and the receiver.
    bit quiet_phase   = 1'b0;
    bit long_hold_req = 1'b0;
    int long_holds    = 0;
    int quiet_cycles  = 0;

    // Per-command tallies for the closing summary.
    int puts_sent;
    int offscreen_sent;
    int reads_sent;
    int clears_sent;
    int unused_sent;

    always #5 clk = ~clk;

    text_console_char_writer u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (req_valid),
        .o_s_tready (req_ready),
        .i_s_tdata  (req_data),
        .o_m_tvalid (res_valid),
        .i_m_tready (res_ready),
        .o_m_tdata  (res_data)
    );

    console_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .i_req_ready    (req_ready),
        .i_req_data     (req_data),
        .i_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .i_res_data     (res_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_scroll_count (scroll_count)
    );

    function automatic t_console_req make_request(input logic [1:0] cmd,
                                                  input logic [7:0] char_code,
                                                  input logic [7:0] attr,
                                                  input logic use_cursor,
                                                  input logic [7:0] col,
                                                  input logic [7:0] row);
        t_console_req req;
        req            = '0;
        req.cmd        = cmd;
        req.char_code  = char_code;
        req.attr       = attr;
        req.use_cursor = use_cursor;
        req.col        = col;
        req.row        = row;
        return req;
    endfunction

    // Mostly typing at the cursor, with reads, placed writes (biased toward the
    // bottom rows so scrolling happens often) and a few clears and unused commands.
    function automatic t_console_req random_console_request();
        t_console_req req;
        int           pick;
        req            = '0;
        req.char_code  = 8'($urandom_range(0, 255));
        req.attr       = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        req.use_cursor = 1'b1;
        req.col        = 8'($urandom_range(0, 255));
        req.row        = 8'($urandom_range(0, 255));
        pick           = $urandom_range(0, 999);
        if (pick < 700) begin
            req.cmd = CMD_PUT;
            case ($urandom_range(0, 19))
                0, 1:    req.char_code = CH_NEWLINE;
                2:       req.char_code = CH_BACKSPACE;
                3, 4, 5: ;
                default: req.char_code = 8'($urandom_range(32, 126));
            endcase
        end else if (pick < 860) begin
            req.cmd = CMD_READ;
            req.use_cursor = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 6) != 0) begin
                req.col = 8'($urandom_range(0, COLUMNS_DEF - 1));
                req.row = 8'($urandom_range(0, ROWS_DEF - 1));
            end
        end else if (pick < 965) begin
            req.cmd        = CMD_PUT;
            req.use_cursor = 1'b0;
            if ($urandom_range(0, 6) != 0) begin
                req.col = 8'($urandom_range(0, COLUMNS_DEF - 1));
                req.row = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(ROWS_DEF - 2,
                                                                           ROWS_DEF - 1))
                                                      : 8'($urandom_range(0, ROWS_DEF - 1));
            end
            case ($urandom_range(0, 9))
                0, 1:    req.char_code = CH_NEWLINE;
                2:       req.char_code = CH_BACKSPACE;
                default: ;
            endcase
        end else if (pick < 985) begin
            req.cmd = CMD_UNUSED;
        end else begin
            req.cmd = CMD_CLEAR;
        end
        return req;
    endfunction

    // Offers one request, with an occasional idle burst first, and returns at the
    // falling edge after it was taken.
    task automatic send_console_request(input t_console_req req);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        case (req.cmd)
            CMD_PUT: begin
                puts_sent++;
                if (!req.use_cursor && (int'(req.col) >= COLUMNS_DEF ||
                                        int'(req.row) >= ROWS_DEF))
                    offscreen_sent++;
            end
            CMD_READ:  reads_sent++;
            CMD_CLEAR: clears_sent++;
            default:   unused_sent++;
        endcase
        @(negedge clk);
    endtask

    // Stops offering and waits until every outstanding result has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    // Result side: random short stalls, one long hold-off on request, none at the end.
    initial begin
        bit hold_now;
        bit quiet_now;
        forever begin
            @(posedge clk);
            hold_now  = long_hold_req;
            quiet_now = quiet_phase;
            @(negedge clk);
            if (hold_now) begin
                res_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_hold_req = 1'b0;
                long_holds++;
            end else if (!quiet_now && $urandom_range(0, 5) == 0) begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Ends the run if neither stream moves for too long.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no handshake for %0d cycles", $time,
                     WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests: field extremes, every command and the corner cases.
        send_console_request(make_request(CMD_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0));
        send_console_request(make_request(CMD_PUT, 8'h41, 8'h00, 1'b1, 8'd0, 8'd0));
        send_console_request(make_request(CMD_PUT, 8'hFF, 8'hFF, 1'b0, 8'd79, 8'd24));
        send_console_request(make_request(CMD_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd23));
        send_console_request(make_request(CMD_PUT, CH_BACKSPACE, 8'h00, 1'b1, 8'd0, 8'd0));
        send_console_request(make_request(CMD_PUT, CH_BACKSPACE, 8'h55, 1'b0, 8'd0, 8'd0));
        send_console_request(make_request(CMD_PUT, CH_NEWLINE, 8'h00, 1'b1, 8'd0, 8'd0));
        send_console_request(make_request(CMD_PUT, CH_NEWLINE, 8'h00, 1'b0, 8'd5, 8'd24));
        send_console_request(make_request(CMD_PUT, 8'h58, 8'h12, 1'b0, 8'd80, 8'd0));
        send_console_request(make_request(CMD_PUT, 8'h58, 8'h12, 1'b0, 8'd0, 8'd25));
        send_console_request(make_request(CMD_PUT, 8'h58, 8'h12, 1'b0, 8'd255, 8'd255));
        send_console_request(make_request(CMD_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd24));
        send_console_request(make_request(CMD_READ, 8'h00, 8'h00, 1'b0, 8'd80, 8'd0));
        send_console_request(make_request(CMD_READ, 8'hFF, 8'hFF, 1'b1, 8'd255, 8'd255));
        send_console_request(make_request(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, 8'd255, 8'd255));
        send_console_request(make_request(CMD_CLEAR, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0));
        send_console_request(make_request(CMD_READ, 8'h00, 8'h00, 1'b0, 8'd40, 8'd12));
        send_console_request(make_request(CMD_PUT, 8'h00, 8'hFF, 1'b1, 8'd255, 8'd255));
        send_console_request(make_request(CMD_PUT, 8'hFF, 8'h80, 1'b0, 8'd0, 8'd0));
        send_console_request(make_request(CMD_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0));
        send_console_request(make_request(CMD_PUT, 8'h7E, 8'h01, 1'b0, 8'd79, 8'd23));
        send_console_request(make_request(CMD_PUT, CH_BACKSPACE, 8'h00, 1'b1, 8'd0, 8'd0));
        send_console_request(make_request(CMD_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd23));
        drain_results();

        // Random traffic. One chunk carries a long result hold-off, another ends
        // with a full drain, and the last chunk runs without any idling.
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            if (chunk == RANDOM_CHUNKS - 1) quiet_phase = 1'b1;
            for (int k = 0; k < CHUNK_ITEMS; k++) begin
                if (chunk == 2 && k == 10) long_hold_req = 1'b1;
                send_console_request(random_console_request());
            end
            if (chunk == 3) drain_results();
        end
        drain_results();
        repeat (20) @(posedge clk);

        $display("Sent %0d puts (%0d off screen), %0d reads, %0d clears, %0d unused commands.",
                 puts_sent, offscreen_sent, reads_sent, clears_sent, unused_sent);
        $display("The screen scrolled %0d times; the result side held off %0d long stretches.",
                 scroll_count, long_holds);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/tcw_pkg.sv
sv/tcw_cell_mem.sv
sv/text_console_char_writer.sv
sim/console_result_checker.sv
sim/tb_top.sv
